@@ rtl/core/gha_pkg.sv @@
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and constants for the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int HANDLE_COUNT = 256;
  localparam int HANDLE_W     = 8;
  localparam int GEN_W        = 8;
  localparam int POOL_BYTES   = 16384;
  localparam int OFF_W        = 14;
  localparam int LINK_W       = 15;
  localparam int SIZE_CLASSES = 4096;
  localparam int SIZE_W       = 12;
  localparam int CNT_W        = 9;

  // list terminator, one past the last byte offset
  localparam logic [LINK_W-1:0] NO_SLOT    = LINK_W'(POOL_BYTES);
  localparam logic [LINK_W-1:0] STEP_LIMIT = LINK_W'(POOL_BYTES);
  localparam logic [GEN_W-1:0]  GEN_MAX    = '1;

  typedef enum logic [1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_CHECK   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK            = 2'd0,
    STS_NO_HANDLE     = 2'd1,
    STS_POOL_FULL     = 2'd2,
    STS_GEN_EXHAUSTED = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t                command;
    logic [HANDLE_W-1:0] handle_index;
    logic [GEN_W-1:0]    generation_in;
    logic [SIZE_W-1:0]   size_bytes;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [HANDLE_W-1:0] handle_out;
    logic [GEN_W-1:0]    generation_out;
    logic [OFF_W-1:0]    slot_offset;
    logic                valid_res;
  } res_t;

endpackage

@@ rtl/core/gha_ram.sv @@
// ----------------------------------------------------------------------------
// gha_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gha_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-before-write on a same-address collision
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/gha_seq.sv @@
// ----------------------------------------------------------------------------
// gha_seq
// Command sequencer: reads handle and list state, walks free lists and
// writes back. Holds the size-class head clearing pass after reset.
// ----------------------------------------------------------------------------
module gha_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  gha_pkg::req_t in_req,
  output logic          res_valid,
  input  logic          res_ready,
  output gha_pkg::res_t res
);
  import gha_pkg::*;

  localparam int CLR_W = $clog2(SIZE_CLASSES);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_AQ_GEN, S_TT, S_AQ_WR, S_AP_ISS, S_AP, S_DONE
  } state_t;

  state_t               st_r;
  logic [CLR_W-1:0]     clr_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [OFF_W-1:0]     bump_r;
  req_t                 req_r;
  res_t                 res_r;
  logic [LINK_W-1:0]    cur_r;
  logic [LINK_W-1:0]    head_r;
  logic [OFF_W-1:0]     hold_r;
  logic                 hold_head_r;
  logic [LINK_W-1:0]    steps_r;
  logic                 from_list_r;
  logic [OFF_W-1:0]     slot_r;
  logic [HANDLE_COUNT-1:0] gvld_r;
  logic [HANDLE_COUNT-1:0] svld_r;
  logic                 gvld_q;
  logic                 svld_q;
  logic [HANDLE_W-1:0]  stk_ra_q;

  // memory ports
  logic                 gen_we, stk_we, soff_we, head_we, link_we;
  logic [HANDLE_W-1:0]  gen_wa, gen_ra, stk_wa, stk_ra, soff_wa, soff_ra;
  logic [GEN_W-1:0]     gen_wd, gen_rd;
  logic [HANDLE_W-1:0]  stk_wd, stk_rd;
  logic [OFF_W-1:0]     soff_wd, soff_rd;
  logic [SIZE_W-1:0]    head_wa, head_ra;
  logic [LINK_W-1:0]    head_wd, head_rd;
  logic [OFF_W-1:0]     link_wa, link_ra;
  logic [LINK_W-1:0]    link_wd, link_rd;

  logic [GEN_W-1:0]     gen_v;
  logic [HANDLE_W-1:0]  stk_v;
  logic                 head_has;
  logic                 bump_fits;
  logic                 rel_ok;
  logic                 link_more;

  gha_ram #(.DEPTH(HANDLE_COUNT), .WIDTH(GEN_W)) u_gen (
    .clk(clk), .we(gen_we), .waddr(gen_wa), .wdata(gen_wd), .raddr(gen_ra), .rdata(gen_rd)
  );
  gha_ram #(.DEPTH(HANDLE_COUNT), .WIDTH(HANDLE_W)) u_stk (
    .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd)
  );
  gha_ram #(.DEPTH(HANDLE_COUNT), .WIDTH(OFF_W)) u_soff (
    .clk(clk), .we(soff_we), .waddr(soff_wa), .wdata(soff_wd), .raddr(soff_ra),
    .rdata(soff_rd)
  );
  gha_ram #(.DEPTH(SIZE_CLASSES), .WIDTH(LINK_W)) u_head (
    .clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd), .raddr(head_ra),
    .rdata(head_rd)
  );
  gha_ram #(.DEPTH(POOL_BYTES), .WIDTH(LINK_W)) u_link (
    .clk(clk), .we(link_we), .waddr(link_wa), .wdata(link_wd), .raddr(link_ra),
    .rdata(link_rd)
  );

  // entries never written read as their reset value
  assign gen_v     = gvld_q ? gen_rd : '0;
  assign stk_v     = svld_q ? stk_rd : stk_ra_q;
  assign head_has  = head_rd < NO_SLOT;
  assign bump_fits = ({1'b0, bump_r} + LINK_W'(req_r.size_bytes)) < LINK_W'(POOL_BYTES);
  assign rel_ok    = gen_v != GEN_MAX;
  assign link_more = (link_rd < NO_SLOT) && (steps_r < STEP_LIMIT);

  assign in_ready  = st_r == S_IDLE;
  assign res_valid = st_r == S_DONE;
  assign res       = res_r;

  always_comb begin
    gen_ra  = in_req.handle_index;
    soff_ra = in_req.handle_index;
    stk_ra  = HANDLE_W'(cnt_r - CNT_W'(1));
    head_ra = in_req.size_bytes;
    link_ra = cur_r[OFF_W-1:0];
    gen_we  = 1'b0;
    gen_wa  = req_r.handle_index;
    gen_wd  = gen_v + GEN_W'(1);
    stk_we  = 1'b0;
    stk_wa  = cnt_r[HANDLE_W-1:0];
    stk_wd  = req_r.handle_index;
    soff_we = 1'b0;
    soff_wa = res_r.handle_out;
    soff_wd = slot_r;
    head_we = 1'b0;
    head_wa = req_r.size_bytes;
    head_wd = NO_SLOT;
    link_we = 1'b0;
    link_wa = soff_rd;
    link_wd = NO_SLOT;
    case (st_r)
      S_CLEAR: begin
        head_we = 1'b1;
        head_wa = clr_r;
      end
      S_RD: begin
        gen_ra = stk_v;
        if (req_r.command == CMD_RELEASE && rel_ok) begin
          gen_we  = 1'b1;
          stk_we  = cnt_r < CNT_W'(HANDLE_COUNT);
          link_we = 1'b1;
          if (!head_has) begin
            head_we = 1'b1;
            head_wd = {1'b0, soff_rd};
          end
        end
      end
      S_AQ_GEN: link_ra = head_r[OFF_W-1:0];
      S_TT: begin
        link_ra = link_rd[OFF_W-1:0];
        if (!link_more) begin
          if (hold_head_r) begin
            head_we = 1'b1;
          end else begin
            link_we = 1'b1;
            link_wa = hold_r;
          end
        end
      end
      S_AQ_WR: soff_we = 1'b1;
      S_AP: begin
        link_ra = link_rd[OFF_W-1:0];
        if (!link_more) begin
          link_we = 1'b1;
          link_wa = cur_r[OFF_W-1:0];
          link_wd = {1'b0, slot_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    gvld_q   <= gvld_r[gen_ra];
    svld_q   <= svld_r[stk_ra];
    stk_ra_q <= stk_ra;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_CLEAR;
      clr_r  <= '0;
      cnt_r  <= CNT_W'(HANDLE_COUNT);
      bump_r <= '0;
      gvld_r <= '0;
      svld_r <= '0;
    end else begin
      case (st_r)
        S_CLEAR: begin
          clr_r <= clr_r + CLR_W'(1);
          if (clr_r == CLR_W'(SIZE_CLASSES - 1)) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            req_r <= in_req;
            st_r  <= S_RD;
          end
        end
        S_RD: begin
          res_r.status         <= STS_OK;
          res_r.handle_out     <= req_r.handle_index;
          res_r.generation_out <= gen_v;
          res_r.slot_offset    <= '0;
          res_r.valid_res      <= 1'b0;
          st_r                 <= S_DONE;
          case (req_r.command)
            CMD_ACQUIRE: begin
              if (cnt_r == '0) begin
                res_r.status <= STS_NO_HANDLE;
              end else if (!head_has && !bump_fits) begin
                res_r.status <= STS_POOL_FULL;
              end else begin
                cnt_r            <= cnt_r - CNT_W'(1);
                res_r.handle_out <= stk_v;
                from_list_r      <= head_has;
                head_r           <= head_rd;
                st_r             <= S_AQ_GEN;
              end
            end
            CMD_RELEASE: begin
              res_r.slot_offset <= soff_rd;
              if (!rel_ok) begin
                res_r.status <= STS_GEN_EXHAUSTED;
              end else begin
                gvld_r[req_r.handle_index] <= 1'b1;
                if (cnt_r < CNT_W'(HANDLE_COUNT)) begin
                  svld_r[cnt_r[HANDLE_W-1:0]] <= 1'b1;
                  cnt_r <= cnt_r + CNT_W'(1);
                end
                res_r.generation_out <= gen_v + GEN_W'(1);
                slot_r  <= soff_rd;
                cur_r   <= head_rd;
                steps_r <= '0;
                if (head_has) st_r <= S_AP_ISS;
              end
            end
            CMD_CHECK: begin
              res_r.slot_offset <= soff_rd;
              res_r.valid_res   <= gen_v == req_r.generation_in;
            end
            default: begin
              res_r <= '0;
            end
          endcase
        end
        S_AQ_GEN: begin
          res_r.generation_out <= gen_v;
          if (from_list_r) begin
            cur_r       <= head_r;
            hold_head_r <= 1'b1;
            steps_r     <= '0;
            st_r        <= S_TT;
          end else begin
            res_r.slot_offset <= bump_r;
            slot_r <= bump_r;
            bump_r <= bump_r + OFF_W'(req_r.size_bytes);
            st_r   <= S_AQ_WR;
          end
        end
        S_TT: begin
          if (link_more) begin
            hold_r      <= cur_r[OFF_W-1:0];
            hold_head_r <= 1'b0;
            cur_r       <= link_rd;
            steps_r     <= steps_r + LINK_W'(1);
          end else begin
            slot_r            <= cur_r[OFF_W-1:0];
            res_r.slot_offset <= cur_r[OFF_W-1:0];
            st_r              <= S_AQ_WR;
          end
        end
        S_AQ_WR:  st_r <= S_DONE;
        S_AP_ISS: st_r <= S_AP;
        S_AP: begin
          if (link_more) begin
            cur_r   <= link_rd;
            steps_r <= steps_r + LINK_W'(1);
          end else begin
            st_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(HANDLE_COUNT))
    else $error("free handle count above capacity");

  a_walk_node: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_TT || st_r == S_AP) |-> cur_r < NO_SLOT)
    else $error("list walk on terminator");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    steps_r <= STEP_LIMIT || !(st_r == S_TT || st_r == S_AP))
    else $error("list walk past limit");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_IDLE && in_valid |=> st_r == S_RD && res_valid == 1'b0)
    else $error("accepted word not started");

endmodule

@@ rtl/core/generational_handle_allocator_top.sv @@
// Path: check, failed commands and release onto an empty list take S_RD and S_DONE;
//   acquire S_RD, S_AQ_GEN, S_TT on a free list, S_AQ_WR, S_DONE; release onto a
//   list S_RD, S_AP_ISS, S_AP, S_DONE (one link read per cycle in S_TT and S_AP).
// Throughput: one word at a time; the next is taken once the result is registered.
// Reset: rst_n synchronous; a pass then clears the size-class heads,
//   in_tready stays low meanwhile.
// ----------------------------------------------------------------------------
// generational_handle_allocator_top
// Handle allocator with generation counters and per-size free slot lists.
// ----------------------------------------------------------------------------
module generational_handle_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // command[1:0], handle_index[9:2],
                                  // generation_in[17:10], size_bytes[29:18]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status[1:0], handle_out[9:2], generation_out[17:10],
                                  // slot_offset[31:18], valid_res[32]
);
  import gha_pkg::*;

  req_t        req;
  res_t        res;
  logic        res_valid;
  logic        res_ready;
  logic        out_valid_r;
  logic [39:0] out_data_r;

  assign req.command       = cmd_t'(in_tdata[1:0]);
  assign req.handle_index  = in_tdata[9:2];
  assign req.generation_in = in_tdata[17:10];
  assign req.size_bytes    = in_tdata[29:18];

  gha_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_req   (req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
      out_data_r  <= {7'd0, res.valid_res, res.slot_offset, res.generation_out,
                      res.handle_out, res.status};
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ tb/generational_handle_allocator_top_tb.sv @@
// ----------------------------------------------------------------------------
// generational_handle_allocator_top_tb
// Self-checking bench for the handle allocator: a short table of directed
// words, then phases that drain the handle stack, wear one generation out,
// run random traffic and fill the pool, checked against the table or a model.
// ----------------------------------------------------------------------------
module generational_handle_allocator_top_tb;
  import gha_pkg::*;

  localparam int WATCHDOG_LIMIT = 50000;
  localparam int RANDOM_WORDS   = 170;
  localparam int LONG_HOLD      = 400;
  // first of the classes each taking one release while a generation wears out
  localparam int EXHAUST_CLASS  = SIZE_CLASSES - 257;

  typedef struct {
    cmd_t        cmd;
    bit [7:0]    idx;
    bit [7:0]    gin;
    bit [11:0]   size;
    bit          typed;
    res_t        want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  generational_handle_allocator_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // allocator model state
  int unsigned free_stack [HANDLE_COUNT];
  int unsigned free_cnt;
  int unsigned gen_of     [HANDLE_COUNT];
  int unsigned off_of     [HANDLE_COUNT];
  int unsigned bump;
  int unsigned class_head [SIZE_CLASSES];
  int unsigned next_link  [POOL_BYTES];

  res_t        pending_res [$];
  res_t        last_res;
  bit          granted   [HANDLE_COUNT];
  int unsigned live_hdl  [$];
  int          fails;
  int          results_seen;
  int          idle_cycles;
  bit          stim_done;

  function automatic int unsigned link_of(int unsigned off);
    return off < POOL_BYTES ? next_link[off] : POOL_BYTES;
  endfunction

  function automatic int unsigned pop_tail(int unsigned cls);
    int unsigned cur, prev, steps;
    bit          moved;
    cur = class_head[cls];
    prev = 0;
    steps = 0;
    moved = 0;
    while (cur < POOL_BYTES && link_of(cur) < POOL_BYTES && steps < POOL_BYTES) begin
      prev = cur;
      moved = 1;
      cur = next_link[cur];
      steps++;
    end
    if (moved) next_link[prev] = POOL_BYTES;
    else class_head[cls] = POOL_BYTES;
    return cur;
  endfunction

  function automatic void push_tail(int unsigned cls, int unsigned off);
    int unsigned cur, steps;
    if (off >= POOL_BYTES) return;
    next_link[off] = POOL_BYTES;
    cur = class_head[cls];
    if (cur >= POOL_BYTES) begin
      class_head[cls] = off;
      return;
    end
    steps = 0;
    while (link_of(cur) < POOL_BYTES && steps < POOL_BYTES) begin
      cur = next_link[cur];
      steps++;
    end
    next_link[cur] = off;
  endfunction

  function automatic void model_reset();
    for (int i = 0; i < HANDLE_COUNT; i++) begin
      free_stack[i] = i;
      gen_of[i] = 0;
      off_of[i] = 0;
    end
    free_cnt = HANDLE_COUNT;
    bump = 0;
    foreach (class_head[i]) class_head[i] = POOL_BYTES;
    foreach (next_link[i]) next_link[i] = 0;
  endfunction

  function automatic res_t allocate_step(cmd_t cmd, bit [7:0] idx, bit [7:0] gin,
                                         bit [11:0] size);
    res_t        r;
    int unsigned h, slot;
    bit          from_list;
    r = '0;
    case (cmd)
      CMD_ACQUIRE: begin
        from_list = class_head[size] < POOL_BYTES;
        if (free_cnt == 0) r.status = STS_NO_HANDLE;
        else if (!from_list && bump + size >= POOL_BYTES) r.status = STS_POOL_FULL;
        else begin
          free_cnt--;
          h = free_stack[free_cnt] % HANDLE_COUNT;
          if (from_list) slot = pop_tail(size);
          else begin
            slot = bump;
            bump += size;
          end
          off_of[h] = slot;
          r.status = STS_OK;
          r.handle_out = 8'(h);
          r.generation_out = 8'(gen_of[h]);
          r.slot_offset = 14'(slot);
        end
        if (r.status != STS_OK) begin
          r.handle_out = idx;
          r.generation_out = 8'(gen_of[idx]);
          r.slot_offset = '0;
        end
      end
      CMD_RELEASE: begin
        r.handle_out = idx;
        r.slot_offset = 14'(off_of[idx]);
        if (gen_of[idx] >= 255) begin
          r.status = STS_GEN_EXHAUSTED;
          r.generation_out = 8'(gen_of[idx]);
        end else begin
          gen_of[idx]++;
          // full stack: the push is dropped, the rest still happens
          if (free_cnt < HANDLE_COUNT) begin
            free_stack[free_cnt] = idx;
            free_cnt++;
          end
          push_tail(size, off_of[idx]);
          r.status = STS_OK;
          r.generation_out = 8'(gen_of[idx]);
        end
      end
      CMD_CHECK: begin
        r.status = STS_OK;
        r.handle_out = idx;
        r.generation_out = 8'(gen_of[idx]);
        r.slot_offset = 14'(off_of[idx]);
        r.valid_res = gen_of[idx] == gin;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic send_word(cmd_t cmd, bit [7:0] idx, bit [7:0] gin, bit [11:0] size,
                           bit typed = 0, res_t want = '0);
    int   gap;
    res_t r;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, size, gin, idx, cmd};
    do @(posedge clk); while (!in_tready);
    r = allocate_step(cmd, idx, gin, size);
    pending_res.push_back(typed ? want : r);
    last_res = r;
    if (cmd == CMD_ACQUIRE && r.status == STS_OK) begin
      granted[r.handle_out] = 1;
      // a handle can sit twice on the stack; keep one live copy only
      if (!(r.handle_out inside {live_hdl})) live_hdl.push_back(r.handle_out);
    end
    if (cmd == CMD_RELEASE && r.status == STS_OK)
      foreach (live_hdl[i])
        if (live_hdl[i] == idx) begin
          live_hdl.delete(i);
          break;
        end
  endtask

  task automatic wait_drained();
    while (pending_res.size() != 0) @(posedge clk);
  endtask

  function automatic bit [11:0] pick_size();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return 12'($urandom_range(1, 31));
    if (sel < 97) return 12'($urandom_range(32, 255));
    return 12'($urandom_range(256, SIZE_CLASSES - 2));
  endfunction

  function automatic bit [7:0] pick_granted();
    int unsigned h;
    do h = $urandom_range(0, HANDLE_COUNT - 1); while (!granted[h]);
    return 8'(h);
  endfunction

  stim_row_t dir_tab [15];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: random stalls, one long hold-off to back the block up
  initial begin
    int   n;
    bit   held;
    res_t got, exp_r;
    out_tready = 1'b0;
    held = 0;
    forever begin
      n = $urandom_range(0, 5);
      if (!held && results_seen == 200) begin
        n = LONG_HOLD;
        held = 1;
      end
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      results_seen++;
      got.status         = status_t'(out_tdata[1:0]);
      got.handle_out     = out_tdata[9:2];
      got.generation_out = out_tdata[17:10];
      got.slot_offset    = out_tdata[31:18];
      got.valid_res      = out_tdata[32];
      if (pending_res.size() == 0) begin
        $error("result word with nothing expected: %h", out_tdata);
        fails++;
      end else begin
        exp_r = pending_res.pop_front();
        if (got.status != exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, got.status);
          fails++;
        end
        if (got.handle_out != exp_r.handle_out) begin
          $error("handle_out: expected %0d, got %0d", exp_r.handle_out, got.handle_out);
          fails++;
        end
        if (got.generation_out != exp_r.generation_out) begin
          $error("generation_out: expected %0d, got %0d",
                 exp_r.generation_out, got.generation_out);
          fails++;
        end
        if (got.slot_offset != exp_r.slot_offset) begin
          $error("slot_offset: expected %0d, got %0d", exp_r.slot_offset, got.slot_offset);
          fails++;
        end
        if (got.valid_res != exp_r.valid_res) begin
          $error("valid_res: expected %0d, got %0d", exp_r.valid_res, got.valid_res);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int          sel;
    int          k;
    int unsigned h;
    bit [7:0]    g;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    fails = 0;
    results_seen = 0;
    idle_cycles = 0;
    stim_done = 0;
    foreach (granted[i]) granted[i] = 0;
    model_reset();

    // offset 0 is handed out twice via size 0 and parked on class 4095 only
    dir_tab = '{
      '{CMD_ACQUIRE, 8'h00, 8'h00, 12'h000, 1, '{STS_OK, 8'd255, 8'd0, 14'd0, 1'b0}},
      '{CMD_ACQUIRE, 8'hff, 8'hff, 12'hfff, 1, '{STS_OK, 8'd254, 8'd0, 14'd0, 1'b0}},
      '{CMD_CHECK,   8'd255, 8'h00, 12'h000, 1, '{STS_OK, 8'd255, 8'd0, 14'd0, 1'b1}},
      '{CMD_CHECK,   8'd255, 8'hff, 12'h000, 1, '{STS_OK, 8'd255, 8'd0, 14'd0, 1'b0}},
      '{CMD_NONE,    8'hff, 8'hff, 12'hfff, 1, '{STS_OK, 8'd0, 8'd0, 14'd0, 1'b0}},
      '{CMD_RELEASE, 8'd254, 8'h00, 12'hfff, 1, '{STS_OK, 8'd254, 8'd1, 14'd0, 1'b0}},
      // double release, then release into a full stack
      '{CMD_RELEASE, 8'd254, 8'h00, 12'hfff, 1, '{STS_OK, 8'd254, 8'd2, 14'd0, 1'b0}},
      '{CMD_RELEASE, 8'd255, 8'h00, 12'hfff, 1, '{STS_OK, 8'd255, 8'd1, 14'd0, 1'b0}},
      '{CMD_CHECK,   8'd255, 8'h01, 12'hfff, 1, '{STS_OK, 8'd255, 8'd1, 14'd0, 1'b1}},
      '{CMD_ACQUIRE, 8'h00, 8'h00, 12'd100, 0, '0},
      '{CMD_ACQUIRE, 8'h00, 8'h00, 12'd20,  0, '0},
      '{CMD_ACQUIRE, 8'h00, 8'h00, 12'd1,   0, '0},
      '{CMD_RELEASE, 8'd253, 8'h00, 12'd1,  0, '0},
      '{CMD_ACQUIRE, 8'h03, 8'h05, 12'd1,   0, '0},
      '{CMD_CHECK,   8'd253, 8'h01, 12'd1,  0, '0}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i])
      send_word(dir_tab[i].cmd, dir_tab[i].idx, dir_tab[i].gin, dir_tab[i].size,
                dir_tab[i].typed, dir_tab[i].want);

    // drain the handle stack, one acquire past empty
    while (free_cnt > 0)
      send_word(CMD_ACQUIRE, 8'($urandom), 8'($urandom), 12'($urandom_range(1, 7)));
    send_word(CMD_ACQUIRE, 8'($urandom), 8'($urandom), 12'd2);

    // sender holds until the block is empty, then wears one generation out by
    // repeated release, each into its own empty size class
    in_tvalid <= 1'b0;
    wait_drained();
    h = live_hdl[0];
    k = 0;
    while (gen_of[h] < 255) begin
      send_word(CMD_RELEASE, 8'(h), 8'($urandom), 12'(EXHAUST_CLASS + k));
      k++;
    end
    send_word(CMD_RELEASE, 8'(h), 8'($urandom), 12'(EXHAUST_CLASS + k));
    send_word(CMD_CHECK, 8'(h), 8'hff, 12'($urandom));

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40 || live_hdl.size() == 0)
        send_word(CMD_ACQUIRE, 8'($urandom), 8'($urandom), pick_size());
      else if (sel < 75)
        send_word(CMD_RELEASE, 8'(live_hdl[$urandom_range(0, live_hdl.size() - 1)]),
                  8'($urandom), pick_size());
      else if (sel < 95) begin
        g = pick_granted();
        send_word(CMD_CHECK, g, $urandom_range(0, 1) ? 8'(gen_of[g]) : 8'($urandom),
                  12'($urandom));
      end else
        send_word(CMD_NONE, 8'($urandom), 8'($urandom), 12'($urandom));
    end

    // fill the bump region, then probe both sides of its limit
    while (free_cnt > 0 && bump + 4094 < POOL_BYTES)
      send_word(CMD_ACQUIRE, 8'($urandom), 8'($urandom), 12'd4094);
    send_word(CMD_ACQUIRE, 8'($urandom), 8'($urandom), 12'd4094);
    if (POOL_BYTES - bump <= 4094 && class_head[POOL_BYTES - bump] >= POOL_BYTES)
      send_word(CMD_ACQUIRE, 8'($urandom), 8'($urandom), 12'(POOL_BYTES - bump));
    if (bump < POOL_BYTES - 1 && POOL_BYTES - 1 - bump <= 4094)
      send_word(CMD_ACQUIRE, 8'($urandom), 8'($urandom), 12'(POOL_BYTES - 1 - bump));

    in_tvalid <= 1'b0;
    stim_done = 1;
    wait_drained();
    repeat (50) @(posedge clk);
    if (fails == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/gha_pkg.sv
rtl/core/gha_ram.sv
rtl/core/gha_seq.sv
rtl/core/generational_handle_allocator_top.sv
tb/generational_handle_allocator_top_tb.sv
